[rtl/core/hafb_pkg.sv]
package hafb_pkg;

    localparam int MAX_HOLES_DEF = 16;

    localparam int SIZE_W  = 16;
    localparam int ACT_W   = 2;
    localparam int HIDX_W  = 4;
    localparam int IN_W    = 24;
    localparam int OUT_W   = 24;
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;

    localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_APPEND = 2'd1;
    localparam logic [ACT_W-1:0] ACT_ALLOC  = 2'd2;

    localparam logic [APB_AW-1:0] REG_FIT_MODE = 3'd0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic scan_rd;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic count_zero;
        logic scan_last;
        logic out_busy;
    } t_sts;

endpackage

[rtl/core/hafb_ctrl.sv]
module hafb_ctrl
    import hafb_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic [ACT_W-1:0] i_action,
    input  t_sts             i_sts,
    output logic             o_in_ready,
    output t_cmd             o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_action == ACT_ALLOC && !i_sts.count_zero) begin
                        n_state = ST_SCAN;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_SCAN: begin
                if (i_sts.scan_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!i_sts.out_busy) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready    = 1'b0;
        o_cmd.load    = 1'b0;
        o_cmd.scan_rd = 1'b0;
        o_cmd.finish  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_SCAN: begin
                o_cmd.scan_rd = 1'b1;
            end
            ST_DRAIN: begin
            end
            ST_DONE: begin
                o_cmd.finish = !i_sts.out_busy;
            end
            default: begin
            end
        endcase
    end

endmodule

[rtl/core/hafb_dp.sv]
module hafb_dp
    import hafb_pkg::*;
#(
    parameter int MAX_HOLES = MAX_HOLES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_sts              o_sts,
    input  logic [ACT_W-1:0]  i_action,
    input  logic [SIZE_W-1:0] i_size,
    input  logic              i_fit_mode,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output logic              o_ok,
    output logic [HIDX_W-1:0] o_hole_index,
    output logic [SIZE_W-1:0] o_remaining
);

    localparam int IW = (MAX_HOLES > 1) ? $clog2(MAX_HOLES) : 1;
    localparam int CW = $clog2(MAX_HOLES + 1);

    logic [SIZE_W-1:0] r_mem [MAX_HOLES];
    logic [SIZE_W-1:0] r_rd_data;
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     r_scan;
    logic              r_cmp_vld;
    logic [IW-1:0]     r_cmp_idx;
    logic [ACT_W-1:0]  r_act;
    logic [SIZE_W-1:0] r_req;
    logic              r_found;
    logic [IW-1:0]     r_pick;
    logic [SIZE_W-1:0] r_pick_size;
    logic              r_out_vld;
    logic              r_ok;
    logic [HIDX_W-1:0] r_idx;
    logic [SIZE_W-1:0] r_rem;

    logic              take;
    logic              full;
    logic              mem_we;
    logic [IW-1:0]     mem_wa;
    logic [SIZE_W-1:0] mem_wd;
    logic [SIZE_W-1:0] left;

    // In first fit the first fitting hole wins; best fit replaces it only by a
    // strictly smaller one, so ties keep the lowest index.
    assign take = r_cmp_vld && (r_rd_data >= r_req)
                  && (!r_found || (i_fit_mode && (r_rd_data < r_pick_size)));
    assign full = (r_count == CW'(MAX_HOLES));
    assign left = r_pick_size - r_req;

    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_pick;
        mem_wd = left;
        if (i_cmd.finish) begin
            if (r_act == ACT_APPEND && !full) begin
                mem_we = 1'b1;
                mem_wa = r_count[IW-1:0];
                mem_wd = r_req;
            end else if (r_act == ACT_ALLOC && r_found) begin
                mem_we = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (i_cmd.scan_rd) begin
            r_rd_data <= r_mem[r_scan[IW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_cmp_vld <= 1'b0;
            r_out_vld <= 1'b0;
            r_found   <= 1'b0;
            r_scan    <= '0;
        end else begin
            r_cmp_vld <= i_cmd.scan_rd;
            if (i_cmd.load) begin
                r_found <= 1'b0;
                r_scan  <= '0;
            end else begin
                if (i_cmd.scan_rd) begin
                    r_scan <= CW'(r_scan + 1'b1);
                end
                if (take) begin
                    r_found <= 1'b1;
                end
            end
            if (i_cmd.finish) begin
                r_out_vld <= 1'b1;
                if (r_act == ACT_CLEAR) begin
                    r_count <= '0;
                end else if (r_act == ACT_APPEND && !full) begin
                    r_count <= CW'(r_count + 1'b1);
                end
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_act <= i_action;
            r_req <= i_size;
        end
        if (i_cmd.scan_rd) begin
            r_cmp_idx <= r_scan[IW-1:0];
        end
        if (take) begin
            r_pick      <= r_cmp_idx;
            r_pick_size <= r_rd_data;
        end
        if (i_cmd.finish) begin
            case (r_act)
                ACT_CLEAR: begin
                    r_ok  <= 1'b1;
                    r_idx <= '0;
                    r_rem <= '0;
                end
                ACT_APPEND: begin
                    r_ok  <= !full;
                    r_idx <= full ? '0 : HIDX_W'(r_count);
                    r_rem <= full ? '0 : r_req;
                end
                ACT_ALLOC: begin
                    r_ok  <= r_found;
                    r_idx <= r_found ? HIDX_W'(r_pick) : '0;
                    r_rem <= r_found ? left : '0;
                end
                default: begin
                    r_ok  <= 1'b0;
                    r_idx <= '0;
                    r_rem <= '0;
                end
            endcase
        end
    end

    assign o_sts.count_zero = (r_count == '0);
    assign o_sts.scan_last  = (CW'(r_scan + 1'b1) == r_count);
    assign o_sts.out_busy   = r_out_vld && !i_out_ready;

    assign o_out_valid  = r_out_vld;
    assign o_ok         = r_ok;
    assign o_hole_index = r_idx;
    assign o_remaining  = r_rem;

endmodule

[rtl/core/hole_allocator_first_best_fit.sv]
// Channel   Direction  Handshake               Payload
// s_*       in         s_tvalid / s_tready     s_tdata: action, size
// m_*       out        m_tvalid / m_tready     m_tdata: ok, hole_index, remaining
// APB       in         psel & penable & pwrite register 0: fit_mode
//
// Clear, append, unused codes and an allocation on an empty table go from IDLE
// straight to DONE. Other allocations scan the n filled holes through the
// registered read port, one entry a cycle, then pass DRAIN before DONE.
// Reset is synchronous and active low; the table keeps no reset contents.
// A result waits in the output register; the next transaction is accepted
// meanwhile and finishes once that register is free.
module hole_allocator_first_best_fit
    import hafb_pkg::*;
#(
    parameter int MAX_HOLES = MAX_HOLES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [IN_W-1:0]   s_tdata,   // [1:0] action, [17:2] size, [23:18] zero
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OUT_W-1:0]  m_tdata,   // [0] ok, [4:1] hole_index, [20:5] remaining
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    t_cmd              cmd;
    t_sts              sts;
    logic              r_fit_mode;
    logic              ok;
    logic [HIDX_W-1:0] hole_index;
    logic [SIZE_W-1:0] remaining;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fit_mode <= 1'b0;
        end else if (psel && penable && pwrite && paddr == REG_FIT_MODE) begin
            r_fit_mode <= pwdata[0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == REG_FIT_MODE) ? {{(APB_DW-1){1'b0}}, r_fit_mode} : '0;

    hafb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_tvalid),
        .i_action   (s_tdata[ACT_W-1:0]),
        .i_sts      (sts),
        .o_in_ready (s_tready),
        .o_cmd      (cmd)
    );

    hafb_dp #(
        .MAX_HOLES (MAX_HOLES)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_action     (s_tdata[ACT_W-1:0]),
        .i_size       (s_tdata[ACT_W+SIZE_W-1:ACT_W]),
        .i_fit_mode   (r_fit_mode),
        .i_out_ready  (m_tready),
        .o_out_valid  (m_tvalid),
        .o_ok         (ok),
        .o_hole_index (hole_index),
        .o_remaining  (remaining)
    );

    assign m_tdata = {{(OUT_W-1-HIDX_W-SIZE_W){1'b0}}, remaining, hole_index, ok};

endmodule
